// ----- src/sacc_pkg.sv -----
// ----------------------------------------------------------------------------
// Six-axis conditioner package
// Shared types, codes and constants for the controller, the datapath and the
// iterative divide and square-root unit.
// ----------------------------------------------------------------------------
package sacc_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FULL_SCALE,
    CFG_PAN_DZ,
    CFG_TILT_DZ,
    CFG_TWIST_DZ,
    CFG_ZOOM_DOWN_DZ,
    CFG_ZOOM_UP_DZ,
    CFG_PAN_GAIN,
    CFG_ZOOM_GAIN
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [14:0]        FullScaleRst  = 15'd2100;
  localparam logic [14:0]        PanDzRst      = 15'd4915;
  localparam logic [14:0]        TiltDzRst     = 15'd4915;
  localparam logic [14:0]        TwistDzRst    = 15'd4915;
  localparam logic [14:0]        ZoomDownDzRst = 15'd6554;
  localparam logic [14:0]        ZoomUpDzRst   = 15'd1638;
  localparam logic signed [23:0] PanGainRst    = -24'sd2752512;
  localparam logic signed [23:0] ZoomGainRst   = -24'sd4129;

  // Axis slots in the value file.
  localparam logic [2:0] AX_TX = 3'd0;
  localparam logic [2:0] AX_TY = 3'd1;
  localparam logic [2:0] AX_TZ = 3'd2;
  localparam logic [2:0] AX_RX = 3'd3;
  localparam logic [2:0] AX_RY = 3'd4;
  localparam logic [2:0] AX_RZ = 3'd5;
  localparam logic [2:0] AX_LAST = AX_RZ;

  // Normalized one in Q1.15.
  localparam logic [17:0] OneQ15 = 18'd32768;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_NORM, S_NORM_W, S_SAVE, S_SQA, S_SQB, S_MAG_W, S_DZ,
    S_POW_W, S_CA, S_CA_W, S_CB, S_CB_W, S_SC, S_SC_W, S_SC_WB, S_GATE,
    S_MUL, S_RND, S_FIN
  } ctrl_state_e;

  // Datapath operations.
  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_NORM_GO, DP_NORM_WB, DP_SAVE, DP_SQ_A, DP_SQ_B_GO,
    DP_MAG_WB, DP_PAIR_ZERO, DP_PAIR_POW_GO, DP_POW, DP_COMP_GO, DP_COMP_WB,
    DP_SC_ZERO, DP_SC_POW_GO, DP_SC_WB, DP_GATE, DP_MUL, DP_RND, DP_FIN
  } dp_op_e;

  // Command from controller to datapath. The index selects the axis during
  // normalization, the pair or scalar in bit 0, the pair element in bit 1,
  // and the step product in bits 1:0 during the multiply phase.
  typedef struct packed {
    dp_op_e     op;
    logic [2:0] idx;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic       busy;
    logic       zero_evt;
    logic [1:0] pair_dead;
    logic [1:0] scal_dead;
    logic       out_free;
  } dp_status_t;

  // Magnitude of an 18-bit signed value.
  function automatic logic [17:0] mag18(input logic signed [17:0] v);
    logic [17:0] r;
    r = v[17] ? 18'(-v) : 18'(v);
    return r;
  endfunction

  // First and second component of the pan (0) or tilt (1) vector.
  function automatic logic [2:0] pair_a(input logic sel);
    logic [2:0] r;
    r = sel ? AX_RZ : AX_TX;
    return r;
  endfunction

  function automatic logic [2:0] pair_b(input logic sel);
    logic [2:0] r;
    r = sel ? AX_RX : AX_TZ;
    return r;
  endfunction

  // Scalar axis: twist (0) or zoom (1).
  function automatic logic [2:0] scal_axis(input logic sel);
    logic [2:0] r;
    r = sel ? AX_TY : AX_RY;
    return r;
  endfunction

endpackage

// ----- src/sacc_itu.sv -----
// ----------------------------------------------------------------------------
// Iterative divide and square-root unit
// Restoring divider with a 32-bit quotient, one quotient bit per cycle, and
// digit-by-digit square root with a 16-bit root, one root bit per cycle.
// ----------------------------------------------------------------------------
module sacc_itu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        sqrt_i,
  input  logic [31:0] opd_i,
  input  logic [15:0] den_i,
  output logic        busy_o,
  output logic [31:0] res_o
);

  logic        busy_q, busy_d;
  logic        sqrt_q, sqrt_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [17:0] rem_q, rem_d;
  logic [15:0] root_q, root_d;
  logic [15:0] den_q, den_d;

  logic [19:0] rem_sh;
  logic [19:0] trial;
  logic        take;

  // One step of the selected recurrence.
  always_comb begin
    if (sqrt_q) begin
      rem_sh = {rem_q, acc_q[31:30]};
      trial  = {2'b00, root_q, 2'b01};
    end else begin
      rem_sh = {1'b0, rem_q, acc_q[31]};
      trial  = {4'b0000, den_q};
    end
    take = (rem_sh >= trial);
  end

  // Next-state logic.
  always_comb begin
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    root_d = root_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      sqrt_d = sqrt_i;
      cnt_d  = sqrt_i ? 5'd15 : 5'd31;
      acc_d  = opd_i;
      rem_d  = '0;
      root_d = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = take ? 18'(rem_sh - trial) : rem_sh[17:0];
      if (sqrt_q) begin
        acc_d  = {acc_q[29:0], 2'b00};
        root_d = {root_q[14:0], take};
      end else begin
        acc_d = {acc_q[30:0], take};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    sqrt_q <= sqrt_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign res_o  = sqrt_q ? {16'd0, root_q} : acc_q;

endmodule

// ----- src/sacc_dp.sv -----
// ----------------------------------------------------------------------------
// Six-axis conditioner datapath
// Configuration registers, axis value file, locks, the shared iterative unit,
// the step multiplier and the result registers, driven by controller commands.
// ----------------------------------------------------------------------------
module sacc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sacc_pkg::dp_cmd_t                   cmd_i,
  output sacc_pkg::dp_status_t                status_o,
  input  logic                                cfg_we_i,
  input  logic [sacc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [23:0]                         cfg_data_i,
  input  logic                                operation_i,
  input  logic signed [15:0]                  tx_sample_i,
  input  logic signed [15:0]                  ty_sample_i,
  input  logic signed [15:0]                  tz_sample_i,
  input  logic signed [15:0]                  rx_sample_i,
  input  logic signed [15:0]                  ry_sample_i,
  input  logic signed [15:0]                  rz_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [23:0]                  view_pan_x_o,
  output logic signed [23:0]                  view_pan_y_o,
  output logic                                pan_active_o,
  output logic signed [23:0]                  zoom_step_o,
  output logic                                zoom_active_o,
  output logic signed [23:0]                  scroll_step_o,
  output logic                                scroll_active_o,
  output logic                                raw_update_o,
  output logic signed [15:0]                  raw_twist_o,
  output logic signed [15:0]                  raw_zoom_o,
  output logic signed [16:0]                  raw_pan_x_o,
  output logic signed [16:0]                  raw_pan_y_o
);

  import sacc_pkg::*;

  // Configuration registers.
  logic [14:0]        fs_q, pdz_q, tdz_q, wdz_q, zdd_q, zud_q;
  logic signed [23:0] pg_q, zg_q;

  // Item state.
  logic               op_q;
  logic signed [15:0] s_q [6];
  logic signed [17:0] v_q [6];
  logic signed [16:0] rtw_q, rzm_q;
  logic signed [17:0] rpx_q, rpy_q;
  logic [31:0]        sq_q;
  logic [15:0]        m_q, d_q, p_q;
  logic signed [41:0] prod_q;
  logic signed [23:0] res_q [3];
  logic               tl_q, pzl_q;
  logic               out_valid_q;

  // Output registers.
  logic signed [23:0] px_q, py_q, zs_q, ss_q;
  logic               pan_on_q, zoom_on_q, scroll_on_q, upd_q;
  logic signed [15:0] otw_q, ozm_q;
  logic signed [16:0] opx_q, opy_q;

  // Iterative unit connections.
  logic        itu_start, itu_sqrt, itu_busy;
  logic [31:0] itu_opd, itu_res;
  logic [15:0] itu_den;

  // Command decode.
  logic               sel, elem;
  logic [2:0]         ia, ib, ic, sc;
  logic [14:0]        pair_dz, scal_dz, zoom_dz;
  logic signed [15:0] ns;
  logic [17:0]        ns_mag;
  logic [14:0]        fs_eff;
  logic [31:0]        norm_num;
  logic [17:0]        norm_q;
  logic signed [17:0] norm_v;
  logic signed [35:0] sqa_full, sqb_full;
  logic [31:0]        mag_opd;
  logic [15:0]        pair_d;
  logic [17:0]        sc_mag, sc_df;
  logic [31:0]        pow_full;
  logic [17:0]        c_mag;
  logic [32:0]        comp_full;
  logic [17:0]        comp_q;
  logic signed [17:0] mul_a;
  logic signed [23:0] mul_b;
  logic [41:0]        rnd_mag, rnd_div;
  logic [41:0]        rnd_res;

  // Final-step decode.
  logic               pan_on, zoom_on, scroll_on, tl_new, pzl_new, upd;
  logic [17:0]        ry_mag;
  logic [19:0]        scr_t;
  logic [23:0]        scr_q;

  always_comb begin
    sel     = cmd_i.idx[0];
    elem    = cmd_i.idx[1];
    ia      = pair_a(sel);
    ib      = pair_b(sel);
    ic      = elem ? ib : ia;
    sc      = scal_axis(sel);
    pair_dz = sel ? tdz_q : pdz_q;
    zoom_dz = v_q[AX_TY][17] ? zdd_q : zud_q;
    scal_dz = sel ? zoom_dz : wdz_q;

    // Normalization: round(|s| * 32768 / full_scale), limited to one.
    ns       = s_q[cmd_i.idx];
    ns_mag   = ns[15] ? 18'(-18'(ns)) : 18'(ns);
    fs_eff   = (fs_q == 15'd0) ? 15'd1 : fs_q;
    norm_num = {ns_mag[16:0], 15'd0} + 32'(fs_eff >> 1);
    norm_q   = (itu_res > 32'(OneQ15)) ? OneQ15 : itu_res[17:0];
    norm_v   = ns[15] ? -$signed(norm_q) : $signed(norm_q);

    // Sum of squares for the vector magnitude.
    sqa_full = v_q[ia] * v_q[ia];
    sqb_full = v_q[ib] * v_q[ib];
    mag_opd  = sq_q + sqb_full[31:0];

    // Dead-zone offsets.
    pair_d = m_q - {1'b0, pair_dz};
    sc_mag = mag18(v_q[sc]);
    sc_df  = sc_mag - {3'b000, scal_dz};

    // Power 1.5 and component rescale.
    pow_full  = d_q * itu_res[15:0];
    c_mag     = mag18(v_q[ic]);
    comp_full = c_mag[16:0] * p_q;
    comp_q    = itu_res[17:0];

    // Step products.
    case (cmd_i.idx[1:0])
      2'd0: begin
        mul_a = v_q[AX_RZ] + v_q[AX_TX];
        mul_b = pg_q;
      end
      2'd1: begin
        mul_a = v_q[AX_RX] - v_q[AX_TZ];
        mul_b = pg_q;
      end
      default: begin
        mul_a = v_q[AX_TY];
        mul_b = zg_q;
      end
    endcase
    rnd_mag = prod_q[41] ? 42'(-prod_q) : 42'(prod_q);
    rnd_div = (rnd_mag + 42'd262144) >> 19;
    rnd_res = prod_q[41] ? 42'(-rnd_div) : rnd_div;
  end

  // Start of the iterative unit.
  always_comb begin
    itu_start = 1'b0;
    itu_sqrt  = 1'b0;
    itu_opd   = '0;
    itu_den   = '0;
    case (cmd_i.op)
      DP_NORM_GO: begin
        itu_start = 1'b1;
        itu_opd   = norm_num;
        itu_den   = {1'b0, fs_eff};
      end
      DP_SQ_B_GO: begin
        itu_start = 1'b1;
        itu_sqrt  = 1'b1;
        itu_opd   = mag_opd;
      end
      DP_PAIR_POW_GO: begin
        itu_start = 1'b1;
        itu_sqrt  = 1'b1;
        itu_opd   = {1'b0, pair_d, 15'd0};
      end
      DP_SC_POW_GO: begin
        itu_start = 1'b1;
        itu_sqrt  = 1'b1;
        itu_opd   = {1'b0, sc_df[15:0], 15'd0};
      end
      DP_COMP_GO: begin
        itu_start = 1'b1;
        itu_opd   = comp_full[31:0];
        itu_den   = m_q;
      end
      default: begin
        itu_start = 1'b0;
      end
    endcase
  end

  sacc_itu u_itu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (itu_start),
    .sqrt_i  (itu_sqrt),
    .opd_i   (itu_opd),
    .den_i   (itu_den),
    .busy_o  (itu_busy),
    .res_o   (itu_res)
  );

  // Flags, locks and raw report of the final step.
  always_comb begin
    pan_on    = (v_q[AX_RZ] != '0) || (v_q[AX_TX] != '0) ||
                (v_q[AX_RX] != '0) || (v_q[AX_TZ] != '0);
    zoom_on   = (v_q[AX_TY] != '0);
    scroll_on = (v_q[AX_RY] != '0);
    tl_new    = tl_q | scroll_on;
    pzl_new   = pzl_q | pan_on | zoom_on;
    upd       = !(tl_new && pzl_new);
    // Scroll is twist times minus three eighths, rounded to nearest.
    ry_mag    = mag18(v_q[AX_RY]);
    scr_t     = 20'(ry_mag) * 20'd3 + 20'd4;
    scr_q     = {8'd0, scr_t[18:3]};
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q  <= FullScaleRst;
      pdz_q <= PanDzRst;
      tdz_q <= TiltDzRst;
      wdz_q <= TwistDzRst;
      zdd_q <= ZoomDownDzRst;
      zud_q <= ZoomUpDzRst;
      pg_q  <= PanGainRst;
      zg_q  <= ZoomGainRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FULL_SCALE:   fs_q  <= cfg_data_i[14:0];
        CFG_PAN_DZ:       pdz_q <= cfg_data_i[14:0];
        CFG_TILT_DZ:      tdz_q <= cfg_data_i[14:0];
        CFG_TWIST_DZ:     wdz_q <= cfg_data_i[14:0];
        CFG_ZOOM_DOWN_DZ: zdd_q <= cfg_data_i[14:0];
        CFG_ZOOM_UP_DZ:   zud_q <= cfg_data_i[14:0];
        CFG_PAN_GAIN:     pg_q  <= $signed(cfg_data_i);
        CFG_ZOOM_GAIN:    zg_q  <= $signed(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // Locks and output valid. A new result is only loaded when the output
  // register is empty or being taken in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q        <= 1'b0;
      pzl_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_FIN) begin
        out_valid_q <= 1'b1;
        if (op_q) begin
          tl_q  <= 1'b0;
          pzl_q <= 1'b0;
        end else begin
          tl_q  <= tl_new;
          pzl_q <= pzl_new;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Value file and working registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        op_q        <= operation_i;
        s_q[AX_TX]  <= tx_sample_i;
        s_q[AX_TY]  <= ty_sample_i;
        s_q[AX_TZ]  <= tz_sample_i;
        s_q[AX_RX]  <= rx_sample_i;
        s_q[AX_RY]  <= ry_sample_i;
        s_q[AX_RZ]  <= rz_sample_i;
      end
      DP_NORM_WB: v_q[cmd_i.idx] <= norm_v;
      DP_SAVE: begin
        rtw_q <= v_q[AX_RY][16:0];
        rzm_q <= v_q[AX_TY][16:0];
        rpx_q <= v_q[AX_RZ] + v_q[AX_TX];
        rpy_q <= v_q[AX_RX] - v_q[AX_TZ];
      end
      DP_SQ_A:        sq_q <= sqa_full[31:0];
      DP_MAG_WB:      m_q  <= itu_res[15:0];
      DP_PAIR_ZERO: begin
        v_q[ia] <= '0;
        v_q[ib] <= '0;
      end
      DP_PAIR_POW_GO: d_q <= pair_d;
      DP_SC_POW_GO:   d_q <= sc_df[15:0];
      DP_POW:         p_q <= pow_full[30:15];
      DP_COMP_WB: begin
        v_q[ic] <= v_q[ic][17] ? -$signed(comp_q) : $signed(comp_q);
      end
      DP_SC_ZERO:     v_q[sc] <= '0;
      DP_SC_WB: begin
        v_q[sc] <= v_q[sc][17] ? -$signed({2'b00, p_q}) : $signed({2'b00, p_q});
      end
      DP_GATE: begin
        if (tl_q) begin
          v_q[AX_TX] <= '0;
          v_q[AX_TY] <= '0;
          v_q[AX_TZ] <= '0;
          v_q[AX_RX] <= '0;
          v_q[AX_RZ] <= '0;
        end
        if (pzl_q) begin
          v_q[AX_RY] <= '0;
        end
      end
      DP_MUL:         prod_q <= mul_a * mul_b;
      // The step magnitude stays below 2^21, so no saturation is needed.
      DP_RND:         res_q[cmd_i.idx[1:0]] <= rnd_res[23:0];
      DP_FIN: begin
        if (op_q) begin
          px_q        <= '0;
          py_q        <= '0;
          zs_q        <= '0;
          ss_q        <= '0;
          pan_on_q    <= 1'b0;
          zoom_on_q   <= 1'b0;
          scroll_on_q <= 1'b0;
          upd_q       <= 1'b1;
          otw_q       <= '0;
          ozm_q       <= '0;
          opx_q       <= '0;
          opy_q       <= '0;
        end else begin
          px_q        <= pan_on ? res_q[0] : '0;
          py_q        <= pan_on ? res_q[1] : '0;
          zs_q        <= zoom_on ? res_q[2] : '0;
          ss_q        <= v_q[AX_RY][17] ? $signed(scr_q) : -$signed(scr_q);
          pan_on_q    <= pan_on;
          zoom_on_q   <= zoom_on;
          scroll_on_q <= scroll_on;
          upd_q       <= upd;
          if (upd && pzl_new) begin
            otw_q <= '0;
            ozm_q <= (rzm_q > 17'sd32767) ? 16'sd32767 : rzm_q[15:0];
            opx_q <= (rpx_q > 18'sd65535) ? 17'sd65535 : rpx_q[16:0];
            opy_q <= (rpy_q > 18'sd65535) ? 17'sd65535 : rpy_q[16:0];
          end else if (upd) begin
            otw_q <= (rtw_q > 17'sd32767) ? 16'sd32767 : rtw_q[15:0];
            ozm_q <= '0;
            opx_q <= '0;
            opy_q <= '0;
          end else begin
            otw_q <= '0;
            ozm_q <= '0;
            opx_q <= '0;
            opy_q <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Status to the controller.
  always_comb begin
    status_o.busy         = itu_busy;
    status_o.zero_evt     = op_q;
    status_o.pair_dead[0] = (m_q <= {1'b0, pdz_q});
    status_o.pair_dead[1] = (m_q <= {1'b0, tdz_q});
    status_o.scal_dead[0] = (mag18(v_q[AX_RY]) < {3'b000, wdz_q});
    status_o.scal_dead[1] = (mag18(v_q[AX_TY]) < {3'b000, zoom_dz});
    status_o.out_free     = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign view_pan_x_o    = px_q;
  assign view_pan_y_o    = py_q;
  assign pan_active_o    = pan_on_q;
  assign zoom_step_o     = zs_q;
  assign zoom_active_o   = zoom_on_q;
  assign scroll_step_o   = ss_q;
  assign scroll_active_o = scroll_on_q;
  assign raw_update_o    = upd_q;
  assign raw_twist_o     = otw_q;
  assign raw_zoom_o      = ozm_q;
  assign raw_pan_x_o     = opx_q;
  assign raw_pan_y_o     = opy_q;

endmodule

// ----- src/sacc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Six-axis conditioner controller
// Sequences normalization, dead zones, power curve, locks and step products
// by issuing one datapath command per cycle, a no-operation while it waits.
// ----------------------------------------------------------------------------
module sacc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sacc_pkg::dp_status_t  status_i,
  output sacc_pkg::dp_cmd_t     cmd_o
);

  import sacc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [2:0]  idx_q, idx_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmd_o.op  = DP_NOP;
    cmd_o.idx = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        idx_d   = '0;
        state_d = status_i.zero_evt ? S_FIN : S_NORM;
      end
      S_NORM: begin
        cmd_o.op = DP_NORM_GO;
        state_d  = S_NORM_W;
      end
      S_NORM_W: begin
        if (!status_i.busy) begin
          cmd_o.op = DP_NORM_WB;
          if (idx_q == AX_LAST) begin
            state_d = S_SAVE;
          end else begin
            idx_d   = idx_q + 3'd1;
            state_d = S_NORM;
          end
        end
      end
      S_SAVE: begin
        cmd_o.op = DP_SAVE;
        idx_d    = '0;
        state_d  = S_SQA;
      end
      S_SQA: begin
        cmd_o.op = DP_SQ_A;
        state_d  = S_SQB;
      end
      S_SQB: begin
        cmd_o.op = DP_SQ_B_GO;
        state_d  = S_MAG_W;
      end
      S_MAG_W: begin
        if (!status_i.busy) begin
          cmd_o.op = DP_MAG_WB;
          state_d  = S_DZ;
        end
      end
      S_DZ: begin
        if (status_i.pair_dead[idx_q[0]]) begin
          cmd_o.op = DP_PAIR_ZERO;
          idx_d    = idx_q[0] ? 3'd0 : 3'd1;
          state_d  = idx_q[0] ? S_SC : S_SQA;
        end else begin
          cmd_o.op = DP_PAIR_POW_GO;
          state_d  = S_POW_W;
        end
      end
      S_POW_W: begin
        if (!status_i.busy) begin
          cmd_o.op = DP_POW;
          state_d  = S_CA;
        end
      end
      S_CA: begin
        cmd_o.op  = DP_COMP_GO;
        cmd_o.idx = {2'b00, idx_q[0]};
        state_d   = S_CA_W;
      end
      S_CA_W: begin
        cmd_o.idx = {2'b00, idx_q[0]};
        if (!status_i.busy) begin
          cmd_o.op = DP_COMP_WB;
          state_d  = S_CB;
        end
      end
      S_CB: begin
        cmd_o.op  = DP_COMP_GO;
        cmd_o.idx = {2'b01, idx_q[0]};
        state_d   = S_CB_W;
      end
      S_CB_W: begin
        cmd_o.idx = {2'b01, idx_q[0]};
        if (!status_i.busy) begin
          cmd_o.op = DP_COMP_WB;
          idx_d    = idx_q[0] ? 3'd0 : 3'd1;
          state_d  = idx_q[0] ? S_SC : S_SQA;
        end
      end
      S_SC: begin
        if (status_i.scal_dead[idx_q[0]]) begin
          cmd_o.op = DP_SC_ZERO;
          idx_d    = idx_q[0] ? 3'd0 : 3'd1;
          state_d  = idx_q[0] ? S_GATE : S_SC;
        end else begin
          cmd_o.op = DP_SC_POW_GO;
          state_d  = S_SC_W;
        end
      end
      S_SC_W: begin
        if (!status_i.busy) begin
          cmd_o.op = DP_POW;
          state_d  = S_SC_WB;
        end
      end
      S_SC_WB: begin
        cmd_o.op = DP_SC_WB;
        idx_d    = idx_q[0] ? 3'd0 : 3'd1;
        state_d  = idx_q[0] ? S_GATE : S_SC;
      end
      S_GATE: begin
        cmd_o.op = DP_GATE;
        idx_d    = '0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = DP_MUL;
        state_d  = S_RND;
      end
      S_RND: begin
        cmd_o.op = DP_RND;
        if (idx_q == 3'd2) begin
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.op = DP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- src/six_axis_controller_conditioner.sv -----
// ----------------------------------------------------------------------------
// Six-axis controller conditioner
// Normalizes six raw axis samples, applies dead zones, a power 1.5 response
// and the twist and pan-or-zoom locks, and reports scaled view steps.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one transaction per item (operation plus six raw
// samples) while in_valid_i is high and in_stall_o is low. The output channel
// presents one result transaction per item on out_valid_o; it is taken when
// out_stall_i is low. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i while the block is idle.
// A motion item's processing time is set by the shared divide and
// square-root unit, which runs six normalizing divisions, one magnitude root
// per vector, one more root and two divisions per live vector, and one root
// per live scalar axis, each followed by a write-back. A zero event skips the
// arithmetic and goes from the check state straight to the final step. One
// item is in work at a time, so a new item is not taken before the last one
// has reached its final step; in_stall_o is low only while the controller is
// idle. A result waiting under out_stall_i does not block the next item, but
// that item's result waits for the output.
// Reset clears the locks, the output valid and the controller, and loads
// the default configuration.
// ----------------------------------------------------------------------------
module six_axis_controller_conditioner (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sacc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [23:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic signed [15:0]            tx_sample_i,
  input  logic signed [15:0]            ty_sample_i,
  input  logic signed [15:0]            tz_sample_i,
  input  logic signed [15:0]            rx_sample_i,
  input  logic signed [15:0]            ry_sample_i,
  input  logic signed [15:0]            rz_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [23:0]            view_pan_x_o,
  output logic signed [23:0]            view_pan_y_o,
  output logic                          pan_active_o,
  output logic signed [23:0]            zoom_step_o,
  output logic                          zoom_active_o,
  output logic signed [23:0]            scroll_step_o,
  output logic                          scroll_active_o,
  output logic                          raw_update_o,
  output logic signed [15:0]            raw_twist_o,
  output logic signed [15:0]            raw_zoom_o,
  output logic signed [16:0]            raw_pan_x_o,
  output logic signed [16:0]            raw_pan_y_o
);

  import sacc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  sacc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  sacc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .tx_sample_i     (tx_sample_i),
    .ty_sample_i     (ty_sample_i),
    .tz_sample_i     (tz_sample_i),
    .rx_sample_i     (rx_sample_i),
    .ry_sample_i     (ry_sample_i),
    .rz_sample_i     (rz_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .view_pan_x_o    (view_pan_x_o),
    .view_pan_y_o    (view_pan_y_o),
    .pan_active_o    (pan_active_o),
    .zoom_step_o     (zoom_step_o),
    .zoom_active_o   (zoom_active_o),
    .scroll_step_o   (scroll_step_o),
    .scroll_active_o (scroll_active_o),
    .raw_update_o    (raw_update_o),
    .raw_twist_o     (raw_twist_o),
    .raw_zoom_o      (raw_zoom_o),
    .raw_pan_x_o     (raw_pan_x_o),
    .raw_pan_y_o     (raw_pan_y_o)
  );

`ifndef SYNTHESIS
  // An accepted item always occupies the block in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while idle afterwards");

  // A new result only appears at the end of an item in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result produced without an item in work");

  // The iterative unit never runs while the controller is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !status.busy)
    else $error("iterative unit busy while idle");
`endif

endmodule
